FILE: hw/rtl/shp_pkg.sv
// Package: payload types, constants and round helpers for the sponge hash.
package shp_pkg;

	localparam int TotalRoundsDef = 18;
	localparam logic [63:0] RcLo = 64'h13198A2E03707344;
	localparam logic [63:0] RcHi = 64'h243F6A8885A308D3;
	localparam logic [63:0] Lane16 = 64'h0001000100010001;

	typedef logic [5:0][3:0][63:0] rows_t;

	typedef struct packed {
		logic [63:0] msg_word;
		logic [6:0]  valid_bits;
		logic        final_word;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        digest_last;
	} out_item_t;

	function automatic logic [63:0] rot16(input logic [63:0] x, input logic [3:0] n);
		logic [63:0] r;
		r = x;
		for (int l = 0; l < 4; l++) begin
			r[l*16 +: 16] = 16'({x[l*16 +: 16], x[l*16 +: 16]} >> n);
		end
		return r;
	endfunction

	function automatic rows_t nonlin(input rows_t s, input int src, input int dst,
			input logic [3:0] a, input logic [3:0] b, input logic [3:0] g);
		rows_t t;
		logic [63:0] x;
		t = s;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 4; k++) begin
				x = s[src+i][k];
				t[dst+i][k] = s[dst+i][k] ^ ((rot16(x, a) & rot16(x, b)) ^ rot16(x, g));
			end
		end
		return t;
	endfunction

	function automatic rows_t cross_mix(input rows_t s);
		rows_t t;
		logic [63:0] x03, x14, x25;
		t = s;
		for (int k = 0; k < 4; k++) begin
			x03 = s[0][k] ^ s[3][k];
			x14 = s[1][k] ^ s[4][k];
			x25 = s[2][k] ^ s[5][k];
			t[0][k] = s[0][k] ^ x14; t[1][k] = s[1][k] ^ x25; t[2][k] = s[2][k] ^ x03;
			t[3][k] = s[3][k] ^ x14; t[4][k] = s[4][k] ^ x25; t[5][k] = s[5][k] ^ x03;
		end
		return t;
	endfunction

	function automatic rows_t swap_halves(input rows_t s);
		rows_t t;
		t = s;
		for (int r = 3; r < 6; r++) begin
			t[r][0] = s[r][2]; t[r][1] = s[r][3];
			t[r][2] = s[r][0]; t[r][3] = s[r][1];
		end
		return t;
	endfunction

	function automatic rows_t mix_columns(input rows_t s);
		rows_t t;
		for (int k = 0; k < 4; k++) begin
			t[0][k] = s[1][k] ^ s[2][k];
			t[1][k] = s[0][k] ^ s[2][k];
			t[2][k] = s[0][k] ^ s[1][k] ^ s[2][k];
			t[3][k] = s[3][k] ^ s[5][k];
			t[4][k] = s[4][k] ^ s[5][k];
			t[5][k] = s[4][k] ^ s[3][k] ^ s[5][k];
		end
		return t;
	endfunction

	function automatic logic [127:0] lane_rot(input logic [127:0] v, input logic [3:0] nb);
		logic [6:0] sh;
		sh = {nb, 3'b000};
		return 128'({v, v} >> sh);
	endfunction

	function automatic logic [3:0] lrot(input int i, input int h);
		logic [3:0] r;
		r = 4'(i*4 + h*2);
		return r;
	endfunction

	function automatic logic [3:0] rrot(input int i, input int h);
		logic [3:0] r;
		case (i*2 + h)
			0: r = 4'd0;
			1: r = 4'd14;
			2: r = 4'd12;
			3: r = 4'd10;
			4: r = 4'd8;
			default: r = 4'd6;
		endcase
		return r;
	endfunction

	function automatic rows_t shift_rows(input rows_t s, input int lg, input int rg);
		rows_t t;
		logic [127:0] v;
		t = s;
		for (int i = 0; i < 3; i++) begin
			for (int h = 0; h < 2; h++) begin
				v = lane_rot({s[lg+i][2*h+1], s[lg+i][2*h]}, lrot(i, h));
				t[lg+i][2*h] = v[63:0]; t[lg+i][2*h+1] = v[127:64];
				v = lane_rot({s[rg+i][2*h+1], s[rg+i][2*h]}, rrot(i, h));
				t[rg+i][2*h] = v[63:0]; t[rg+i][2*h+1] = v[127:64];
			end
		end
		return t;
	endfunction

	function automatic rows_t mix_rows(input rows_t s);
		rows_t t;
		logic [3:0][31:0] w;
		for (int r = 0; r < 6; r++) begin
			for (int ln = 0; ln < 2; ln++) begin
				w = {s[r][2*ln+1], s[r][2*ln]};
				for (int i = 0; i < 4; i++) begin
					t[r][2*ln + i/2][(i%2)*32 +: 32] = w[i] ^ w[(i+1)%4] ^ w[(i+3)%4];
				end
			end
		end
		return t;
	endfunction

	function automatic rows_t add_const(input rows_t s, input logic [4:0] rn);
		rows_t t;
		logic [63:0] rep;
		t = s;
		rep = {4{11'd0, rn}};
		t[0][0] = s[0][0] ^ RcLo ^ rep;
		t[0][1] = s[0][1] ^ RcHi ^ rep;
		return t;
	endfunction

	function automatic rows_t round_fwd(input rows_t s0, input logic [4:0] rn);
		rows_t s;
		s = swap_halves(cross_mix(s0));
		s = nonlin(s, 0, 3, 4'd0, 4'd1, 4'd8);
		s = nonlin(s, 3, 0, 4'd14, 4'd5, 4'd0);
		s = nonlin(s, 0, 3, 4'd9, 4'd12, 4'd8);
		s = nonlin(s, 3, 0, 4'd14, 4'd5, 4'd0);
		s = nonlin(s, 0, 3, 4'd0, 4'd1, 4'd8);
		s = nonlin(s, 3, 0, 4'd8, 4'd9, 4'd0);
		s = swap_halves(cross_mix(s));
		s = mix_rows(shift_rows(mix_columns(s), 0, 3));
		return add_const(s, rn);
	endfunction

	function automatic rows_t round_inv(input rows_t s0, input logic [4:0] rn);
		rows_t s, t;
		s = mix_rows(add_const(s0, rn));
		s = mix_columns(shift_rows(s, 3, 0));
		s = cross_mix(swap_halves(s));
		s = nonlin(s, 3, 0, 4'd8, 4'd9, 4'd0);
		s = nonlin(s, 0, 3, 4'd0, 4'd1, 4'd8);
		s = nonlin(s, 3, 0, 4'd14, 4'd5, 4'd0);
		s = nonlin(s, 0, 3, 4'd9, 4'd12, 4'd8);
		s = nonlin(s, 3, 0, 4'd14, 4'd5, 4'd0);
		s = nonlin(s, 0, 3, 4'd0, 4'd1, 4'd8);
		for (int i = 0; i < 3; i++) begin
			t[i] = s[i+3];
			t[i+3] = s[i];
		end
		return cross_mix(swap_halves(t));
	endfunction

endpackage

FILE: hw/rtl/shp_round.sv
// Shared round unit: one forward and one inverse round per cycle on two copies.
module shp_round (
	input  shp_pkg::rows_t   fwd_in,
	input  shp_pkg::rows_t   inv_in,
	input  logic [4:0]       fwd_rn,
	input  logic [4:0]       inv_rn,
	output shp_pkg::rows_t   fwd_out,
	output shp_pkg::rows_t   inv_out
);
	import shp_pkg::*;

	assign fwd_out = round_fwd(fwd_in, fwd_rn);
	assign inv_out = round_inv(inv_in, inv_rn);
endmodule

FILE: hw/rtl/sponge_hash_512_top.sv
// Top level of the sponge hash: absorb sequencer, permutation loop, digest output.
// Usage: message words arrive on the in channel (in_valid/in_stall/in_data), with
// final_word set on the last one. Digest words leave on the out channel
// (out_valid/out_stall/out_data), eight per message, digest_last on the eighth.
// A non-final word is absorbed into the state; if it closes a 15-word block, the
// permutation runs TOTAL_ROUNDS/2 rounds of each kind, one forward and one inverse
// round per cycle in the shared round unit, then folds the two copies.
// A final word runs one or two permutations (two when it fills the block), then
// presents eight digest words, one per cycle while out_stall is low.
// in_stall stays high during a permutation and while digest words remain.
// A stalled digest word holds. Reset clears the state and the word count and
// drops any pending output.
module sponge_hash_512_top #(
	parameter int TOTAL_ROUNDS = shp_pkg::TotalRoundsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  shp_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output shp_pkg::out_item_t out_data
);
	import shp_pkg::*;

	localparam int Half = TOTAL_ROUNDS / 2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PERM = 4'b0010,
		ST_PAD  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t      state_q;
	rows_t       st_q, a_q, b_q, fwd_o, inv_o;
	logic [3:0]  cnt_q;
	logic [4:0]  rnd_q;
	logic        fin_q;
	logic        extra_q;
	logic [2:0]  oidx_q;
	logic [63:0] word_m;
	logic [6:0]  vb;
	logic [9:0]  pos;
	logic        accept;

	shp_round u_round (
		.fwd_in(a_q), .inv_in(b_q),
		.fwd_rn(rnd_q), .inv_rn(5'(Half - 1) - rnd_q + 5'(Half)),
		.fwd_out(fwd_o), .inv_out(inv_o)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word = st_q[{2'b00, oidx_q[2]}][oidx_q[1:0]];
	assign out_data.digest_last = (oidx_q == 3'd7);

	always_comb begin
		vb = (in_data.valid_bits > 7'd64) ? 7'd64 : in_data.valid_bits;
		word_m = in_data.msg_word;
		if (in_data.final_word && vb < 7'd64) begin
			word_m = in_data.msg_word & ((64'd1 << vb[5:0]) - 64'd1);
		end
		pos = {cnt_q, 6'd0} + {3'd0, vb};
	end

	function automatic rows_t put_pad(input rows_t s, input logic [9:0] p);
		rows_t t;
		t = s;
		t[{1'b0, p[9:8]}][p[7:6]][p[5:0]] = t[{1'b0, p[9:8]}][p[7:6]][p[5:0]] ^ 1'b1;
		if (p != 10'd959) begin
			t[3][2][63] = t[3][2][63] ^ 1'b1;
		end
		return t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q <= '0;
			a_q <= '0;
			b_q <= '0;
			cnt_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			extra_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rows_t ns;
						ns = st_q;
						ns[{1'b0, cnt_q[3:2]}][cnt_q[1:0]] =
							st_q[{1'b0, cnt_q[3:2]}][cnt_q[1:0]] ^ word_m;
						rnd_q <= '0;
						if (!in_data.final_word) begin
							st_q <= ns;
							if (cnt_q == 4'd14) begin
								cnt_q <= '0;
								a_q <= ns; b_q <= ns;
								fin_q <= 1'b0;
								state_q <= ST_PERM;
							end else begin
								cnt_q <= cnt_q + 4'd1;
							end
						end else begin
							fin_q <= 1'b1;
							cnt_q <= '0;
							if (pos >= 10'd960) begin
								st_q <= ns;
								a_q <= ns; b_q <= ns;
								extra_q <= 1'b1;
							end else begin
								st_q <= put_pad(ns, pos);
								a_q <= put_pad(ns, pos); b_q <= put_pad(ns, pos);
								extra_q <= 1'b0;
							end
							state_q <= ST_PERM;
						end
					end
				end
				ST_PERM: begin
					// advance both copies; fold after the last round
					if (rnd_q == 5'(Half)) begin
						st_q <= a_q ^ b_q;
						state_q <= !fin_q ? ST_IDLE : (extra_q ? ST_PAD : ST_OUT);
						oidx_q <= '0;
					end else begin
						a_q <= fwd_o;
						b_q <= inv_o;
						rnd_q <= rnd_q + 5'd1;
					end
				end
				ST_PAD: begin
					extra_q <= 1'b0;
					rnd_q <= '0;
					st_q <= put_pad(st_q, 10'd0);
					a_q <= put_pad(st_q, 10'd0);
					b_q <= put_pad(st_q, 10'd0);
					state_q <= ST_PERM;
				end
				ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							st_q <= '0;
							fin_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during digest output");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(oidx_q))
		else $error("stalled digest word moved");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.digest_last |=> !out_valid && cnt_q == 4'd0)
		else $error("digest did not end cleanly");
endmodule

FILE: tb/tb_sponge_hash_512_top.sv
// Testbench for sponge_hash_512_top: random messages checked against an in-bench model.
`timescale 1ns / 100ps

module tb_sponge_hash_512_top;
	import shp_pkg::*;

	localparam int HalfRounds = TotalRoundsDef / 2;
	localparam int BlockWords = 15;
	localparam int DigestWords = 8;
	localparam int IdleLimit = 2000;

	typedef logic [63:0] lanes_t [6][4];

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	in_item_t pending_words[$];
	out_item_t digest_fifo[$];
	logic [63:0] hash_st[24];
	int unsigned blk_cnt;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned idle_cycles;
	bit failed;
	bit in_taken;

	sponge_hash_512_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rot_lane16(logic [63:0] x, int n);
		logic [63:0] r;
		logic [15:0] v;
		for (int l = 0; l < 4; l++) begin
			v = x[l*16 +: 16];
			r[l*16 +: 16] = (n == 0) ? v : ((v >> n) | (v << (16 - n)));
		end
		return r;
	endfunction

	function automatic void sp_nonlin(ref lanes_t s, input int src, dst, a, b, g);
		logic [63:0] x;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 4; k++) begin
				x = s[src+i][k];
				s[dst+i][k] ^= (rot_lane16(x, a) & rot_lane16(x, b)) ^ rot_lane16(x, g);
			end
	endfunction

	function automatic void sp_cross(ref lanes_t s);
		logic [63:0] x03, x14, x25;
		for (int k = 0; k < 4; k++) begin
			x03 = s[0][k] ^ s[3][k];
			x14 = s[1][k] ^ s[4][k];
			x25 = s[2][k] ^ s[5][k];
			s[0][k] ^= x14; s[1][k] ^= x25; s[2][k] ^= x03;
			s[3][k] ^= x14; s[4][k] ^= x25; s[5][k] ^= x03;
		end
	endfunction

	function automatic void sp_swap(ref lanes_t s);
		logic [63:0] t0, t1;
		for (int r = 3; r < 6; r++) begin
			t0 = s[r][0]; t1 = s[r][1];
			s[r][0] = s[r][2]; s[r][1] = s[r][3];
			s[r][2] = t0; s[r][3] = t1;
		end
	endfunction

	function automatic void sp_columns(ref lanes_t s);
		logic [63:0] a0, a1, a2, a3, a4, a5;
		for (int k = 0; k < 4; k++) begin
			a0 = s[0][k]; a1 = s[1][k]; a2 = s[2][k];
			a3 = s[3][k]; a4 = s[4][k]; a5 = s[5][k];
			s[0][k] = a1 ^ a2; s[1][k] = a0 ^ a2; s[2][k] = a0 ^ a1 ^ a2;
			s[3][k] = a3 ^ a5; s[4][k] = a4 ^ a5; s[5][k] = a4 ^ a3 ^ a5;
		end
	endfunction

	function automatic void sp_shift(ref lanes_t s, input int lg, rg);
		int lr[6] = '{0, 2, 4, 6, 8, 10};
		int rr[6] = '{0, 14, 12, 10, 8, 6};
		logic [127:0] v;
		logic [255:0] vv;
		for (int i = 0; i < 3; i++)
			for (int h = 0; h < 2; h++) begin
				v = {s[lg+i][2*h+1], s[lg+i][2*h]};
				vv = {v, v} >> (lr[2*i+h] * 8);
				v = vv[127:0];
				s[lg+i][2*h] = v[63:0]; s[lg+i][2*h+1] = v[127:64];
				v = {s[rg+i][2*h+1], s[rg+i][2*h]};
				vv = {v, v} >> (rr[2*i+h] * 8);
				v = vv[127:0];
				s[rg+i][2*h] = v[63:0]; s[rg+i][2*h+1] = v[127:64];
			end
	endfunction

	function automatic void sp_rows(ref lanes_t s);
		logic [31:0] w[4];
		logic [31:0] d[4];
		for (int r = 0; r < 6; r++)
			for (int ln = 0; ln < 2; ln++) begin
				{w[1], w[0]} = s[r][2*ln];
				{w[3], w[2]} = s[r][2*ln+1];
				for (int i = 0; i < 4; i++) d[i] = w[i] ^ w[(i+1)%4] ^ w[(i+3)%4];
				s[r][2*ln] = {d[1], d[0]};
				s[r][2*ln+1] = {d[3], d[2]};
			end
	endfunction

	function automatic void sp_const(ref lanes_t s, input int rn);
		logic [63:0] rep;
		rep = {4{16'(rn)}};
		s[0][0] ^= RcLo ^ rep;
		s[0][1] ^= RcHi ^ rep;
	endfunction

	function automatic void sp_fwd(ref lanes_t s, input int rn);
		sp_cross(s); sp_swap(s);
		sp_nonlin(s, 0, 3, 0, 1, 8);
		sp_nonlin(s, 3, 0, 14, 5, 0);
		sp_nonlin(s, 0, 3, 9, 12, 8);
		sp_nonlin(s, 3, 0, 14, 5, 0);
		sp_nonlin(s, 0, 3, 0, 1, 8);
		sp_nonlin(s, 3, 0, 8, 9, 0);
		sp_cross(s); sp_swap(s);
		sp_columns(s);
		sp_shift(s, 0, 3);
		sp_rows(s);
		sp_const(s, rn);
	endfunction

	function automatic void sp_inv(ref lanes_t s, input int rn);
		logic [63:0] t;
		sp_const(s, rn + HalfRounds);
		sp_rows(s);
		sp_shift(s, 3, 0);
		sp_columns(s);
		sp_swap(s); sp_cross(s);
		sp_nonlin(s, 3, 0, 8, 9, 0);
		sp_nonlin(s, 0, 3, 0, 1, 8);
		sp_nonlin(s, 3, 0, 14, 5, 0);
		sp_nonlin(s, 0, 3, 9, 12, 8);
		sp_nonlin(s, 3, 0, 14, 5, 0);
		sp_nonlin(s, 0, 3, 0, 1, 8);
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 4; k++) begin
				t = s[i][k]; s[i][k] = s[i+3][k]; s[i+3][k] = t;
			end
		sp_swap(s); sp_cross(s);
	endfunction

	function automatic void permute_state();
		lanes_t a, b;
		for (int r = 0; r < 6; r++)
			for (int k = 0; k < 4; k++) begin
				a[r][k] = hash_st[4*r+k];
				b[r][k] = hash_st[4*r+k];
			end
		for (int r = 0; r < HalfRounds; r++) sp_fwd(a, r);
		for (int r = HalfRounds; r > 0; r--) sp_inv(b, r - 1);
		for (int r = 0; r < 6; r++)
			for (int k = 0; k < 4; k++) hash_st[4*r+k] = a[r][k] ^ b[r][k];
	endfunction

	// absorb one word; on a final word pad, squeeze eight digest words and clear
	function automatic void absorb_word(in_item_t w);
		logic [63:0] m;
		int vb, p;
		out_item_t d;
		m = w.msg_word;
		if (!w.final_word) begin
			hash_st[blk_cnt] ^= m;
			blk_cnt++;
			if (blk_cnt >= BlockWords) begin
				permute_state();
				blk_cnt = 0;
			end
			return;
		end
		vb = (w.valid_bits > 64) ? 64 : int'(w.valid_bits);
		if (vb < 64) m &= (64'd1 << vb) - 64'd1;
		hash_st[blk_cnt] ^= m;
		p = blk_cnt * 64 + vb;
		if (p >= BlockWords * 64) begin
			permute_state();
			p = 0;
		end
		hash_st[p / 64] ^= 64'd1 << (p % 64);
		if (p != BlockWords * 64 - 1) hash_st[14] ^= 64'd1 << 63;
		permute_state();
		for (int k = 0; k < DigestWords; k++) begin
			d.digest_word = hash_st[k];
			d.digest_last = (k == DigestWords - 1);
			digest_fifo.push_back(d);
		end
		foreach (hash_st[i]) hash_st[i] = '0;
		blk_cnt = 0;
	endfunction

	function automatic in_item_t mk_word(logic [63:0] m, logic [6:0] vb, logic fw);
		in_item_t w;
		w.msg_word = m;
		w.valid_bits = vb;
		w.final_word = fw;
		return w;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// message of nwords with random body; the last word carries vb
	function automatic void queue_msg(int nwords, logic [6:0] vb);
		for (int i = 0; i < nwords - 1; i++)
			pending_words.push_back(mk_word(rnd64(), 7'($urandom), 1'b0));
		pending_words.push_back(mk_word(rnd64(), vb, 1'b1));
	endfunction

	function automatic logic [6:0] rnd_vb();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd64;
			2: return 7'($urandom_range(65, 127));
			3: return 7'd63;
			default: return 7'($urandom_range(1, 63));
		endcase
	endfunction

	// sender: hold a presented word until it is taken, then present the next
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				in_taken = 1'b0;
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_words[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// monitor: model accepted words, check digest words
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (in_valid && !in_stall) begin
				absorb_word(in_data);
				void'(pending_words.pop_front());
				in_taken = 1'b1;
				idle_cycles <= 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles <= 0;
				if (digest_fifo.size() == 0) begin
					$display("%0t: unexpected digest word %h last %b", $time,
						out_data.digest_word, out_data.digest_last);
					failed = 1'b1;
				end else begin
					if (out_data.digest_word !== digest_fifo[0].digest_word ||
							out_data.digest_last !== digest_fifo[0].digest_last)
						begin
						$display("%0t: digest mismatch: expected %h/%b actual %h/%b", $time,
							digest_fifo[0].digest_word, digest_fifo[0].digest_last,
							out_data.digest_word, out_data.digest_last);
						failed = 1'b1;
					end
					void'(digest_fifo.pop_front());
				end
			end
			if (idle_cycles >= IdleLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		failed = 1'b0;
		in_taken = 1'b0;
		idle_cycles = 0;
		blk_cnt = 0;
		foreach (hash_st[i]) hash_st[i] = '0;
		send_idle_pct = 16;
		recv_idle_pct = 52;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty, extremes, block boundaries, oversized length
		pending_words.push_back(mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b1));
		pending_words.push_back(mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 1'b1));
		pending_words.push_back(mk_word(64'h0, 7'd127, 1'b1));
		pending_words.push_back(mk_word(64'hFFFF_FFFF_FFFF_FFFF, 7'd63, 1'b1));
		queue_msg(BlockWords, 7'd63);
		queue_msg(BlockWords, 7'd64);
		queue_msg(BlockWords + 1, 7'd0);

		// random: mostly short messages, a few spanning several blocks
		for (int phase = 0; phase < 3; phase++) begin
			for (int n = 0; n < 120; ) begin
				int len;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 46)
					: $urandom_range(1, 6);
				queue_msg(len, rnd_vb());
				n += len;
			end
			wait (pending_words.size() == 0 && digest_fifo.size() == 0);
			if (phase == 0) begin
				send_idle_pct = 52;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		end
		repeat (50) @(posedge clk);
		if (!failed && digest_fifo.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
